### rtl/lemm_pkg.sv
package lemm_pkg;

  localparam int unsigned IdxW     = 10;
  localparam int unsigned CntW     = 8;
  localparam int unsigned LenW     = 12;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;

  // Signed width of edge points and clamp arithmetic: covers -1 up to a full
  // frame length plus the largest mask size.
  localparam int unsigned PtW = LenW + 3;

  // The divider retires two quotient bits per pipeline stage.
  localparam int unsigned DivStages = LenW / 2;

  localparam int unsigned MaskWDefault = 20;
  localparam int unsigned MaskHDefault = 10;

  localparam logic [CntW-1:0] LedsReset   = CntW'(2);
  localparam logic [LenW-1:0] WidthReset  = LenW'(640);
  localparam logic [LenW-1:0] HeightReset = LenW'(480);

  typedef enum logic [1:0] {
    SideLeft,
    SideTop,
    SideRight,
    SideBottom
  } side_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegLedsLeft,
    RegLedsTop,
    RegLedsRight,
    RegLedsBottom,
    RegFrameWidth,
    RegFrameHeight
  } cfg_reg_e;

  // Per-item control that rides alongside the divider.
  typedef struct packed {
    side_e           side;
    logic            bad;
    logic [CntW-1:0] pos;
  } tag_t;

  // One restoring division step: shift in one dividend bit, subtract the
  // divisor if it fits. Returns {quotient bit, new remainder}.
  function automatic logic [CntW:0] div_step(logic [CntW-1:0] rem, logic din,
                                             logic [CntW-1:0] dvs);
    logic [CntW:0] t;
    logic          q;
    t = {rem, din};
    q = (t >= {1'b0, dvs});
    if (q) begin
      t = t - {1'b0, dvs};
    end
    return {q, t[CntW-1:0]};
  endfunction

endpackage

### rtl/lemm_div.sv
module lemm_div import lemm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [LenW-1:0] len_i,
  input  logic [CntW-1:0] div_i,
  input  tag_t            tag_i,
  output logic            out_valid_o,
  output logic [LenW-1:0] quot_o,
  output logic [LenW-1:0] rem_o,
  output tag_t            tag_o
);

  logic [DivStages-1:0] vld_q;
  logic [LenW-1:0]      len_q  [DivStages];
  logic [CntW-1:0]      div_q  [DivStages];
  logic [CntW-1:0]      rem_q  [DivStages];
  logic [LenW-1:0]      quot_q [DivStages];
  tag_t                 tag_q  [DivStages];

  for (genvar k = 0; k < DivStages; k++) begin : g_stage
    localparam int unsigned Hi = LenW - 1 - 2 * k;

    logic            vld_in;
    logic [LenW-1:0] len_in;
    logic [CntW-1:0] div_in;
    logic [CntW-1:0] rem_in;
    logic [LenW-1:0] quot_in;
    tag_t            tag_in;
    logic [CntW:0]   step_hi;
    logic [CntW:0]   step_lo;
    logic [CntW-1:0] rem_d;
    logic [LenW-1:0] quot_d;

    if (k == 0) begin : g_first
      assign vld_in  = in_valid_i;
      assign len_in  = len_i;
      assign div_in  = div_i;
      assign rem_in  = '0;
      assign quot_in = '0;
      assign tag_in  = tag_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign len_in  = len_q[k-1];
      assign div_in  = div_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign quot_in = quot_q[k-1];
      assign tag_in  = tag_q[k-1];
    end

    always_comb begin
      step_hi = div_step(rem_in, len_in[Hi], div_in);
      step_lo = div_step(step_hi[CntW-1:0], len_in[Hi-1], div_in);
      rem_d   = step_lo[CntW-1:0];
      quot_d  = {quot_in[LenW-3:0], step_hi[CntW], step_lo[CntW]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      len_q[k]  <= len_in;
      div_q[k]  <= div_in;
      rem_q[k]  <= rem_d;
      quot_q[k] <= quot_d;
      tag_q[k]  <= tag_in;
    end
  end

  // A side with a single LED has a zero divisor: spacing zero, and the whole
  // length is left over so the LED sits in the middle.
  always_comb begin
    out_valid_o = vld_q[DivStages-1];
    tag_o       = tag_q[DivStages-1];
    if (div_q[DivStages-1] == '0) begin
      quot_o = '0;
      rem_o  = len_q[DivStages-1];
    end else begin
      quot_o = quot_q[DivStages-1];
      rem_o  = {{(LenW-CntW){1'b0}}, rem_q[DivStages-1]};
    end
  end

endmodule

### rtl/led_edge_mask_mapper.sv
// A result appears on result_valid_o once the item taken with start has passed
// one input register, six divider stages, then one stage each for the
// multiply, the edge point and the clamp.
// Throughput: one item per cycle; busy stays low because every stage moves on
// each clock and the receiver cannot stall. Reset clears all valid bits and
// loads the registers with their defaults (2 LEDs per side, 640 x 480 frame).
module led_edge_mask_mapper import lemm_pkg::*; #(
  parameter int unsigned MASK_W = MaskWDefault,
  parameter int unsigned MASK_H = MaskHDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                start,
  output logic                busy,
  input  logic [IdxW-1:0]     led_index_i,
  output logic                result_valid_o,
  output logic [LenW-1:0]     rect_x_o,
  output logic [LenW-1:0]     rect_y_o,
  output logic                index_bad_o
);

  localparam logic signed [PtW-1:0] MaskWS  = PtW'(MASK_W);
  localparam logic signed [PtW-1:0] MaskHS  = PtW'(MASK_H);
  localparam logic signed [PtW-1:0] HalfWS  = PtW'(MASK_W / 2);
  localparam logic signed [PtW-1:0] HalfHS  = PtW'(MASK_H / 2);

  // Centers a mask on point p and clamps it into a frame of length f. When
  // the mask would run past the far edge it is pushed back against that edge,
  // and a frame smaller than the mask leaves the corner at zero.
  function automatic logic [LenW-1:0] clamp_axis(logic signed [PtW-1:0] p,
                                                 logic signed [PtW-1:0] m,
                                                 logic signed [PtW-1:0] half,
                                                 logic [LenW-1:0] f);
    logic signed [PtW-1:0] fs;
    logic signed [PtW-1:0] c;
    logic signed [PtW-1:0] r;
    fs = $signed({{(PtW-LenW){1'b0}}, f});
    c  = p - half;
    if (c + m >= fs) begin
      r = fs - m;
    end else if (c < 0) begin
      r = '0;
    end else begin
      r = c;
    end
    if (r < 0) begin
      r = '0;
    end
    return r[LenW-1:0];
  endfunction

  function automatic logic signed [PtW-1:0] ext(logic [LenW-1:0] v);
    return $signed({{(PtW-LenW){1'b0}}, v});
  endfunction

  // Configuration registers.
  logic [CntW-1:0] leds_left_q, leds_top_q, leds_right_q, leds_bottom_q;
  logic [LenW-1:0] frame_width_q, frame_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leds_left_q     <= LedsReset;
      leds_top_q      <= LedsReset;
      leds_right_q    <= LedsReset;
      leds_bottom_q   <= LedsReset;
      frame_width_q   <= WidthReset;
      frame_height_q  <= HeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegLedsLeft:    leds_left_q    <= cfg_data_i[CntW-1:0];
        RegLedsTop:     leds_top_q     <= cfg_data_i[CntW-1:0];
        RegLedsRight:   leds_right_q   <= cfg_data_i[CntW-1:0];
        RegLedsBottom:  leds_bottom_q  <= cfg_data_i[CntW-1:0];
        RegFrameWidth:  frame_width_q  <= cfg_data_i[LenW-1:0];
        RegFrameHeight: frame_height_q <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // Every stage advances on every clock, so a new item is always welcome.
  assign busy = 1'b0;

  // Side selection. The strip runs left, top, right, bottom, so the running
  // sums of the side counts mark where each side starts. The position along
  // the side, the side length and the divisor (count minus one) are captured
  // in the input register.
  logic [IdxW-1:0] end_left, end_top, end_right, end_bottom;
  logic [IdxW-1:0] base;
  logic [IdxW-1:0] pos_full;
  side_e           side_d;
  logic            bad_d;
  logic [CntW-1:0] cnt_d;
  logic [LenW-1:0] len_d;

  always_comb begin
    end_left   = {{(IdxW-CntW){1'b0}}, leds_left_q};
    end_top    = end_left  + {{(IdxW-CntW){1'b0}}, leds_top_q};
    end_right  = end_top   + {{(IdxW-CntW){1'b0}}, leds_right_q};
    end_bottom = end_right + {{(IdxW-CntW){1'b0}}, leds_bottom_q};
    bad_d      = 1'b0;
    if (led_index_i < end_left) begin
      side_d = SideLeft;
      base   = '0;
      cnt_d  = leds_left_q;
      len_d  = frame_height_q;
    end else if (led_index_i < end_top) begin
      side_d = SideTop;
      base   = end_left;
      cnt_d  = leds_top_q;
      len_d  = frame_width_q;
    end else if (led_index_i < end_right) begin
      side_d = SideRight;
      base   = end_top;
      cnt_d  = leds_right_q;
      len_d  = frame_height_q;
    end else begin
      side_d = SideBottom;
      base   = end_right;
      cnt_d  = leds_bottom_q;
      len_d  = frame_width_q;
      bad_d  = (led_index_i >= end_bottom);
    end
    pos_full = led_index_i - base;
  end

  logic            s_vld_q;
  tag_t            s_tag_q;
  logic [LenW-1:0] s_len_q;
  logic [CntW-1:0] s_div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q <= 1'b0;
    end else begin
      s_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    s_tag_q.side <= side_d;
    s_tag_q.bad  <= bad_d;
    s_tag_q.pos  <= pos_full[CntW-1:0];
    s_len_q      <= len_d;
    s_div_q      <= cnt_d - CntW'(1);
  end

  // Spacing and leftover: the quotient is the LED spacing, and the remainder
  // is exactly the length not covered by the spacing, which is split evenly
  // on both ends.
  logic            d_vld;
  logic [LenW-1:0] d_quot;
  logic [LenW-1:0] d_rem;
  tag_t            d_tag;

  lemm_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_vld_q),
    .len_i       (s_len_q),
    .div_i       (s_div_q),
    .tag_i       (s_tag_q),
    .out_valid_o (d_vld),
    .quot_o      (d_quot),
    .rem_o       (d_rem),
    .tag_o       (d_tag)
  );

  // Multiply stage: position times spacing. The product never exceeds the
  // side length, so the low bits hold it.
  logic [CntW+LenW-1:0] prod_full;
  logic                 m_vld_q;
  tag_t                 m_tag_q;
  logic [LenW-1:0]      m_prod_q;
  logic [LenW-2:0]      m_off_q;

  assign prod_full = {{LenW{1'b0}}, d_tag.pos} * {{CntW{1'b0}}, d_quot};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else begin
      m_vld_q <= d_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    m_tag_q  <= d_tag;
    m_prod_q <= prod_full[LenW-1:0];
    m_off_q  <= d_rem[LenW-1:1];
  end

  // Edge point stage: turn the distance along the side into frame
  // coordinates. Left and bottom run backwards, so they count from the far
  // end; the right edge sits on the last column.
  logic [LenW:0]         along_full;
  logic signed [PtW-1:0] along;
  logic signed [PtW-1:0] px_d, py_d;
  logic                  p_vld_q;
  logic                  p_bad_q;
  logic signed [PtW-1:0] px_q, py_q;

  always_comb begin
    along_full = {1'b0, m_prod_q} + {2'b0, m_off_q};
    along      = ext(along_full[LenW-1:0]);
    unique case (m_tag_q.side)
      SideLeft: begin
        px_d = '0;
        py_d = ext(frame_height_q) - along;
      end
      SideTop: begin
        px_d = along;
        py_d = '0;
      end
      SideRight: begin
        px_d = ext(frame_width_q) - PtW'(1);
        py_d = along;
      end
      SideBottom: begin
        px_d = ext(frame_width_q) - along;
        py_d = ext(frame_height_q) - PtW'(1);
      end
      default: begin
        px_d = '0;
        py_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else begin
      p_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_bad_q <= m_tag_q.bad;
    px_q    <= px_d;
    py_q    <= py_d;
  end

  // Clamp stage feeding the output register. An index past the strip gives
  // a zero corner with the flag set.
  logic            o_vld_q;
  logic [LenW-1:0] o_x_q, o_y_q;
  logic            o_bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else begin
      o_vld_q <= p_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    o_bad_q <= p_bad_q;
    if (p_bad_q) begin
      o_x_q <= '0;
      o_y_q <= '0;
    end else begin
      o_x_q <= clamp_axis(px_q, MaskWS, HalfWS, frame_width_q);
      o_y_q <= clamp_axis(py_q, MaskHS, HalfHS, frame_height_q);
    end
  end

  assign result_valid_o = o_vld_q;
  assign rect_x_o       = o_x_q;
  assign rect_y_o       = o_y_q;
  assign index_bad_o    = o_bad_q;

endmodule
